[src/htfcrc_pkg.sv]
// Shared types and constants for the humidity/temperature frame CRC checker.
// No dependencies; used by htfcrc_crc8 and the top level.
package htfcrc_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT  = 8'h00;
    localparam logic [BYTE_W-1:0] CRC_MSB   = 8'h80;
    localparam logic [WORD_W-1:0] TEMP_MASK = 16'hFFFC;
    localparam logic [WORD_W-1:0] HUMI_MASK = 16'hFFF0;

    // byte positions inside a six-byte frame
    localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_HUMI_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_HUMI_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_HUMI_CRC = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_ERR = 2'd1,
        STATUS_HUMI_ERR = 2'd2
    } frame_status_t;

endpackage

[src/htfcrc_crc8.sv]
// CRC-8 byte update, polynomial 0x31, MSB first, eight shift steps unrolled.
// Depends on htfcrc_pkg.
module htfcrc_crc8
(
    input  logic [htfcrc_pkg::BYTE_W-1:0] crc_in,
    input  logic [htfcrc_pkg::BYTE_W-1:0] data_in,
    output logic [htfcrc_pkg::BYTE_W-1:0] crc_out
);

    logic [htfcrc_pkg::BYTE_W-1:0] c;

    always_comb
    begin
        c = crc_in ^ data_in;
        for (int i = 0; i < htfcrc_pkg::BYTE_W; i++)
        begin
            if ((c & htfcrc_pkg::CRC_MSB) != '0)
                c = {c[htfcrc_pkg::BYTE_W-2:0], 1'b0} ^ htfcrc_pkg::CRC_POLY;
            else
                c = {c[htfcrc_pkg::BYTE_W-2:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

[src/humidity_temp_frame_crc_checker_unit.sv]
// Top level of the humidity/temperature sensor frame CRC checker.
// Depends on htfcrc_pkg and htfcrc_crc8.
//
// Takes one sensor byte per request (temp hi, temp lo, temp CRC, humi hi,
// humi lo, humi CRC) and after the sixth byte delivers one result with the
// masked temperature and humidity words and a status (0 ok, 1 temperature
// CRC bad, 2 humidity CRC bad; temperature wins). A set frame-start flag
// restarts the frame at this byte and drops any partial frame. One byte per
// clock is sustained unless the last byte of a frame waits on a pending
// result. Each byte is held in the input register while the CRC update and
// checks run on it, and results sit in an output register.
module humidity_temp_frame_crc_checker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [15:0] temp_raw, [31:16] humi_raw,
                                   // [33:32] frame_status, [39:34] zero
);

    localparam int BW = htfcrc_pkg::BYTE_W;
    localparam int WW = htfcrc_pkg::WORD_W;
    localparam int PW = htfcrc_pkg::POS_W;

    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;
    logic          in_start_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [BW-1:0] crc_reg, crc_next;
    logic [WW-1:0] temp_reg, temp_next;
    logic [WW-1:0] humi_reg, humi_next;
    logic          temp_fail_reg, temp_fail_next;

    logic                       out_valid_reg;
    logic [WW-1:0]              out_temp_reg, out_temp_next;
    logic [WW-1:0]              out_humi_reg, out_humi_next;
    htfcrc_pkg::frame_status_t  out_status_reg, out_status_next;

    logic [PW-1:0] pos_eff;
    logic          is_last;
    logic          out_free;
    logic          advance;
    logic          load_out;
    logic [BW-1:0] crc_seed;
    logic [BW-1:0] crc_upd;

    assign pos_eff  = (in_start_reg || pos_reg > htfcrc_pkg::POS_HUMI_CRC)
                      ? htfcrc_pkg::POS_TEMP_HI : pos_reg;
    assign is_last  = (pos_eff == htfcrc_pkg::POS_HUMI_CRC);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!is_last || out_free);
    assign load_out = advance && is_last;
    assign s_tready = !in_valid_reg || advance;

    assign crc_seed = (pos_eff == htfcrc_pkg::POS_TEMP_HI || pos_eff == htfcrc_pkg::POS_HUMI_HI)
                      ? htfcrc_pkg::CRC_INIT : crc_reg;

    htfcrc_crc8 u_crc
    (
        .crc_in  (crc_seed),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        pos_next        = pos_eff + PW'(1);
        crc_next        = crc_reg;
        temp_next       = temp_reg;
        humi_next       = humi_reg;
        temp_fail_next  = temp_fail_reg;
        out_temp_next   = temp_reg & htfcrc_pkg::TEMP_MASK;
        out_humi_next   = humi_reg & htfcrc_pkg::HUMI_MASK;
        out_status_next = htfcrc_pkg::STATUS_OK;
        case (pos_eff)
            htfcrc_pkg::POS_TEMP_HI:
            begin
                crc_next       = crc_upd;
                temp_next      = {in_byte_reg, temp_reg[BW-1:0]};
                temp_fail_next = 1'b0;
            end
            htfcrc_pkg::POS_TEMP_LO:
            begin
                crc_next  = crc_upd;
                temp_next = {temp_reg[WW-1:BW], in_byte_reg};
            end
            htfcrc_pkg::POS_TEMP_CRC:
            begin
                temp_fail_next = (crc_reg != in_byte_reg);
                crc_next       = htfcrc_pkg::CRC_INIT;
            end
            htfcrc_pkg::POS_HUMI_HI:
            begin
                crc_next  = crc_upd;
                humi_next = {in_byte_reg, humi_reg[BW-1:0]};
            end
            htfcrc_pkg::POS_HUMI_LO:
            begin
                crc_next  = crc_upd;
                humi_next = {humi_reg[WW-1:BW], in_byte_reg};
            end
            default:
            begin
                if (temp_fail_reg)
                    out_status_next = htfcrc_pkg::STATUS_TEMP_ERR;
                else if (crc_reg != in_byte_reg)
                    out_status_next = htfcrc_pkg::STATUS_HUMI_ERR;
                else
                    out_status_next = htfcrc_pkg::STATUS_OK;
                crc_next = htfcrc_pkg::CRC_INIT;
                pos_next = htfcrc_pkg::POS_TEMP_HI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= htfcrc_pkg::POS_TEMP_HI;
            crc_reg       <= htfcrc_pkg::CRC_INIT;
            temp_reg      <= '0;
            humi_reg      <= '0;
            temp_fail_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_reg      <= temp_next;
            humi_reg      <= humi_next;
            temp_fail_reg <= temp_fail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_temp_reg   <= out_temp_next;
            out_humi_reg   <= out_humi_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(htfcrc_pkg::OUT_TDATA_W - 2*WW - htfcrc_pkg::STATUS_W){1'b0}},
                       out_status_reg, out_humi_reg, out_temp_reg};

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= htfcrc_pkg::POS_HUMI_CRC)
        else $error("byte position out of range");

    a_wrap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> pos_reg == htfcrc_pkg::POS_TEMP_HI)
        else $error("position did not wrap after result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !load_out)
        else $error("pending result overwritten");

    a_temp_status: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && temp_fail_reg |=> out_status_reg == htfcrc_pkg::STATUS_TEMP_ERR)
        else $error("temperature failure not reported");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule
